>>> rtl/core/gha_pkg.sv
// Shared types and codes for the generational handle allocator.
// No dependencies.
`timescale 1ns / 1ps

package gha_pkg;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_ID      = 2'd1;
   localparam logic [1:0] ST_NOT_ISSUED = 2'd2;
   localparam logic [1:0] ST_FULL       = 2'd3;

   typedef struct packed {
      logic pop;
      logic push;
   } queue_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

endpackage

>>> rtl/core/gha_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gha_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/gha_free_queue.sv
// FIFO of freed ids: head/tail pointers, fill count and the queue RAM.
// Depends on gha_pkg and gha_ram.
`timescale 1ns / 1ps

module gha_free_queue #(
   parameter int MAX_IDS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gha_pkg::queue_cmd_type     cmd,
   input  logic [$clog2(MAX_IDS)-1:0] push_id,
   output gha_pkg::queue_stat_type    stat,
   output logic [$clog2(MAX_IDS)-1:0] pop_id
);

   localparam int IDW = $clog2(MAX_IDS);
   localparam int CW  = $clog2(MAX_IDS + 1);
   localparam logic [IDW-1:0] LAST_POS = IDW'(MAX_IDS - 1);

   logic [IDW-1:0] head_ff, head_in;
   logic [IDW-1:0] tail_ff, tail_in;
   logic [CW-1:0]  count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.pop) begin
         head_in = (head_ff == LAST_POS) ? '0 : head_ff + IDW'(1);
      end
      if (cmd.push) begin
         tail_in = (tail_ff == LAST_POS) ? '0 : tail_ff + IDW'(1);
      end
      if (cmd.pop && !cmd.push) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.push && !cmd.pop) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(MAX_IDS));

   gha_ram #(
      .DEPTH (MAX_IDS),
      .WIDTH (IDW)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (tail_ff),
      .wr_data (push_id),
      .rd_en   (cmd.pop),
      .rd_addr (head_ff),
      .rd_data (pop_id)
   );

endmodule

>>> rtl/core/generational_handle_allocator.sv
// Sequence: fresh allocates and rejects go from S_IDLE straight to S_FIN; free and
// check pass through S_VRD to read the version RAM; allocates served from the free list
// pass through S_QRD, then S_VRD. S_FIN waits until the response register is free.
// One request in flight at a time; req_tready is high only in S_IDLE.
// Reset: synchronous; clears pointers, counts and the fresh-id counter. RAM contents
// are not cleared; version entries are written before they are read.
`timescale 1ns / 1ps

module generational_handle_allocator #(
   parameter int MAX_IDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] operation, [11:2] slot_id, [43:12] handle_version, [47:44] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [9:0] granted_id, [41:10] granted_version, [42] is_current, [44:43] status,
   // [47:45] zero
   output logic [47:0] rsp_tdata
);

   localparam int IDW = $clog2(MAX_IDS);
   localparam int CW  = $clog2(MAX_IDS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_QRD,
      S_VRD,
      S_FIN
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]     op_ff, op_in;
   logic [IDW-1:0] id_ff, id_in;
   logic [31:0]    ver_ff, ver_in;
   logic [IDW-1:0] res_id_ff, res_id_in;
   logic [31:0]    res_ver_ff, res_ver_in;
   logic           res_cur_ff, res_cur_in;
   logic [1:0]     res_st_ff, res_st_in;
   logic [CW-1:0]  fresh_ff, fresh_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [47:0]    rsp_data_ff, rsp_data_in;

   logic [1:0]     req_op;
   logic [9:0]     req_id;
   logic [31:0]    req_ver;
   logic [31:0]    req_id32;
   logic [IDW-1:0] req_id_w;
   logic           req_not_issued;
   logic [31:0]    res_id32;
   logic [31:0]    qid32;
   logic [IDW-1:0] qid_fix;

   logic           v_we;
   logic [IDW-1:0] v_waddr;
   logic [31:0]    v_wdata;
   logic           v_re;
   logic [IDW-1:0] v_raddr;
   logic [31:0]    v_rdata;

   gha_pkg::queue_cmd_type  q_cmd;
   gha_pkg::queue_stat_type q_stat;
   logic [IDW-1:0]          q_pop_id;

   assign req_op         = req_tdata[1:0];
   assign req_id         = req_tdata[11:2];
   assign req_ver        = req_tdata[43:12];
   assign req_id32       = 32'(req_id);
   assign req_id_w       = req_id32[IDW-1:0];
   assign req_not_issued = (req_id32 >= 32'(fresh_ff));
   assign res_id32       = 32'(res_id_ff);
   assign qid32          = 32'(q_pop_id);
   assign qid_fix        = (qid32 >= 32'(MAX_IDS)) ? '0 : q_pop_id;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      ver_in       = ver_ff;
      res_id_in    = res_id_ff;
      res_ver_in   = res_ver_ff;
      res_cur_in   = res_cur_ff;
      res_st_in    = res_st_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      v_we         = 1'b0;
      v_waddr      = id_ff;
      v_wdata      = '0;
      v_re         = 1'b0;
      v_raddr      = id_ff;
      q_cmd        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_op;
               id_in      = req_id_w;
               ver_in     = req_ver;
               res_id_in  = '0;
               res_ver_in = '0;
               res_cur_in = 1'b0;
               res_st_in  = gha_pkg::ST_OK;
               state_in   = S_FIN;
               case (req_op)
                  gha_pkg::OP_ALLOC: begin
                     if (!q_stat.empty) begin
                        q_cmd.pop = 1'b1;
                        state_in  = S_QRD;
                     end else if (32'(fresh_ff) < 32'(MAX_IDS)) begin
                        v_we      = 1'b1;
                        v_waddr   = fresh_ff[IDW-1:0];
                        res_id_in = fresh_ff[IDW-1:0];
                        fresh_in  = fresh_ff + CW'(1);
                     end else begin
                        res_st_in = gha_pkg::ST_NO_ID;
                     end
                  end
                  gha_pkg::OP_FREE: begin
                     if (req_not_issued) begin
                        res_st_in = gha_pkg::ST_NOT_ISSUED;
                     end else if (q_stat.full) begin
                        res_st_in = gha_pkg::ST_FULL;
                     end else begin
                        v_re     = 1'b1;
                        v_raddr  = req_id_w;
                        state_in = S_VRD;
                     end
                  end
                  gha_pkg::OP_CHECK: begin
                     if (req_not_issued) begin
                        res_st_in = gha_pkg::ST_NOT_ISSUED;
                     end else begin
                        v_re     = 1'b1;
                        v_raddr  = req_id_w;
                        state_in = S_VRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_QRD: begin
            res_id_in = qid_fix;
            v_re      = 1'b1;
            v_raddr   = qid_fix;
            state_in  = S_VRD;
         end
         S_VRD: begin
            case (op_ff)
               gha_pkg::OP_ALLOC: begin
                  res_ver_in = v_rdata;
               end
               gha_pkg::OP_FREE: begin
                  v_we       = 1'b1;
                  v_waddr    = id_ff;
                  v_wdata    = v_rdata + 32'd1;
                  q_cmd.push = 1'b1;
               end
               default: begin
                  res_cur_in = (v_rdata == ver_ff);
               end
            endcase
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_st_ff, res_cur_ff, res_ver_ff, res_id32[9:0]};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      ver_ff      <= ver_in;
      res_id_ff   <= res_id_in;
      res_ver_ff  <= res_ver_in;
      res_cur_ff  <= res_cur_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   gha_ram #(
      .DEPTH (MAX_IDS),
      .WIDTH (32)
   ) u_version_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_en   (v_re),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   gha_free_queue #(
      .MAX_IDS (MAX_IDS)
   ) u_free_queue (
      .clock   (clock),
      .reset   (reset),
      .cmd     (q_cmd),
      .push_id (id_ff),
      .stat    (q_stat),
      .pop_id  (q_pop_id)
   );

endmodule
